// ----- design/teoq_pkg.sv -----
// ----------------------------------------------------------------------------
// Time-ordered event queue package
// Sizes, payload structs, status codes and the control struct shared by the
// queue cells and the top level.
// ----------------------------------------------------------------------------
package teoq_pkg;

	localparam int DEPTH    = 16;
	localparam int TAG_BITS = 16;

	// Width of the tag field on the ports.
	localparam int TAG_FIELD_W = 16;
	localparam int TIME_W      = 32;

	// Only the low bits of the tag that both the port and the storage allow are kept.
	localparam int TAG_W = (TAG_BITS < TAG_FIELD_W) ? TAG_BITS : TAG_FIELD_W;

	// The occupancy counter holds 0..DEPTH.
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_RETURNED = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_DROPPED  = 2'd3
	} status_t;

	typedef struct packed {
		logic                   opcode;
		logic [TIME_W-1:0]      event_time;
		logic [TAG_FIELD_W-1:0] event_tag;
	} evt_item_t;

	typedef struct packed {
		status_t                status;
		logic [TIME_W-1:0]      out_time;
		logic [TAG_FIELD_W-1:0] out_tag;
	} res_item_t;

	// Contents of one queue slot.
	typedef struct packed {
		logic [TIME_W-1:0] time_v;
		logic [TAG_W-1:0]  tag;
	} slot_t;

	// Broadcast to every cell in the cycle of a transfer.
	typedef struct packed {
		logic  ins;
		logic  pop;
		slot_t item;
	} cell_ctrl_t;

endpackage

// ----- design/time_ordered_event_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Time-ordered event queue unit
// Event calendar kept as a time-sorted row of slot cells, earliest at the head.
// ----------------------------------------------------------------------------
// The queue takes one insert or pop per clock and returns exactly one result
// for each, in the next cycle, through a result register. An insert
// goes before the head when it is strictly earlier, behind the head when the
// head is the only event held, and otherwise just before the first event after
// the head whose time is not earlier, so a new event lands in front of events
// of equal time other than the head. When all DEPTH slots are held the insert
// is dropped with status dropped. A pop returns the head or reports empty. Each
// cell compares its own time against the new event and shifts with its
// neighbor in the same cycle, so the rate is set only by the result
// register: a new item is taken whenever the result slot is free or is being
// taken. Slots need no clearing after reset; only occ_q and res_valid_q reset.
module time_ordered_event_queue_unit
	import teoq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      evt_valid,
	output logic      evt_ready,
	input  evt_item_t evt,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res
);

	logic [CNT_W-1:0] occ_q;
	logic             res_valid_q;
	res_item_t        res_q;

	logic       evt_fire;
	logic       full;
	logic       empty;
	cell_ctrl_t ctrl;
	res_item_t  res_next;

	slot_t            slots [DEPTH];
	logic [DEPTH-1:0] flags;
	logic [DEPTH-1:0] cell_valid;

	assign evt_ready = !res_valid_q || res_ready;
	assign evt_fire  = evt_valid && evt_ready;
	assign full      = (occ_q == CNT_W'(DEPTH));
	assign empty     = (occ_q == '0);

	always_comb begin
		ctrl.ins         = evt_fire && (evt.opcode == OP_INSERT) && !full;
		ctrl.pop         = evt_fire && (evt.opcode == OP_POP) && !empty;
		ctrl.item.time_v = evt.event_time;
		ctrl.item.tag    = evt.event_tag[TAG_W-1:0];
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			slot_t lower;
			logic  lower_flag;
			slot_t upper;

			assign cell_valid[i] = (CNT_W'(i) < occ_q);

			if (i == 0) begin : g_first
				assign lower      = '0;
				assign lower_flag = 1'b0;
			end else begin : g_rest
				assign lower      = slots[i-1];
				assign lower_flag = flags[i-1];
			end

			if (i == DEPTH - 1) begin : g_last
				assign upper = '0;
			end else begin : g_inner
				assign upper = slots[i+1];
			end

			teoq_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.head       (i == 0),
				.valid      (cell_valid[i]),
				.lower      (lower),
				.lower_flag (lower_flag),
				.upper      (upper),
				.slot       (slots[i]),
				.flag       (flags[i])
			);
		end
	endgenerate

	always_comb begin
		res_next = '0;
		if (evt.opcode == OP_INSERT) begin
			res_next.status = full ? ST_DROPPED : ST_INSERTED;
		end else if (empty) begin
			res_next.status = ST_EMPTY;
		end else begin
			res_next.status   = ST_RETURNED;
			res_next.out_time = slots[0].time_v;
			res_next.out_tag  = TAG_FIELD_W'(slots[0].tag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (ctrl.ins) begin
				occ_q <= occ_q + CNT_W'(1);
			end else if (ctrl.pop) begin
				occ_q <= occ_q - CNT_W'(1);
			end
			if (evt_fire) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt_fire) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- design/teoq_cell.sv -----
// ----------------------------------------------------------------------------
// Time-ordered event queue cell
// Holds one slot of the sorted queue. On an insert it keeps its event, takes
// the new event or takes its lower neighbor's event; on a pop it takes its
// upper neighbor's event.
// ----------------------------------------------------------------------------
module teoq_cell
	import teoq_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       head,
	input  logic       valid,
	input  slot_t      lower,
	input  logic       lower_flag,
	input  slot_t      upper,
	output slot_t      slot,
	output logic       flag
);

	slot_t slot_q;

	// The flag is high when the new event belongs at this slot or below it.
	// Since the queue stays sorted, a local compare is enough: the head flags
	// a strictly earlier event, any other held slot flags an event that is not
	// later than its own, and an empty slot always flags.
	always_comb begin
		if (!valid) begin
			flag = 1'b1;
		end else if (head) begin
			flag = (ctrl.item.time_v < slot_q.time_v);
		end else begin
			flag = !(slot_q.time_v < ctrl.item.time_v);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			slot_q <= upper;
		end else if (ctrl.ins) begin
			if (lower_flag) begin
				slot_q <= lower;
			end else if (flag) begin
				slot_q <= ctrl.item;
			end
		end
	end

	assign slot = slot_q;

endmodule

// ----- design/teoq_checker.sv -----
// ----------------------------------------------------------------------------
// Time-ordered event queue checker
// Watches the ports of the queue unit and checks result timing and contents.
// ----------------------------------------------------------------------------
module teoq_checker
	import teoq_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      evt_valid,
	input logic      evt_ready,
	input evt_item_t evt,
	input logic      res_valid,
	input logic      res_ready,
	input res_item_t res
);

	// A stalled result stays put until it is taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed or vanished while stalled");

	// Every input transfer yields a result in the next cycle.
	a_res_follows: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready |=> res_valid)
		else $error("no result after an input transfer");

	// An insert never reports a pop status.
	a_ins_status: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready && (evt.opcode == OP_INSERT)
		|=> (res.status == ST_INSERTED) || (res.status == ST_DROPPED))
		else $error("insert gave a pop status");

	// Only a returned event carries a time and a tag.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status != ST_RETURNED)
		|-> (res.out_time == '0) && (res.out_tag == '0))
		else $error("nonzero time or tag on a result without an event");

endmodule

bind time_ordered_event_queue_unit teoq_checker u_teoq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.evt_valid (evt_valid),
	.evt_ready (evt_ready),
	.evt       (evt),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
